@@ design/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// types and constants shared by the circular fifo queue modules
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int WORD_BITS = 8;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int CAP_W     = PTR_W + 1;
  localparam int CNT_W     = 8;

  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_SLOTS);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_SLOTS);

  typedef enum logic [2:0] {
    CMD_ENQ   = 3'd0,
    CMD_DROP  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_DROPN = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                 we;
    logic [PTR_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [PTR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic             clr;
    logic [CAP_W-1:0] cap;
  } cfg_ctl_t;

endpackage

@@ design/cfq_ram.sv @@
// ----------------------------------------------------------------------------
// cfq_ram
// simple dual port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/cfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfq_ctrl
// head and tail pointers, command decode and the result register
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  cfq_pkg::cfg_ctl_t                cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_cmd,
  input  logic [cfq_pkg::WORD_BITS-1:0]    in_word,
  input  logic [cfq_pkg::CNT_W-1:0]        in_count,
  output cfq_pkg::mem_req_t                mreq,
  input  logic [cfq_pkg::WORD_BITS-1:0]    mem_rdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [cfq_pkg::WORD_BITS-1:0]    out_head_word,
  output logic [cfq_pkg::CNT_W-1:0]        out_moved,
  output logic [cfq_pkg::CNT_W-1:0]        out_fill,
  output logic [cfq_pkg::CNT_W-1:0]        out_free,
  output logic                             out_empty,
  output logic                             out_full
);

  localparam int PW = cfq_pkg::PTR_W;
  localparam int CW = cfq_pkg::CAP_W;

  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;

  logic              accept;
  logic [CW-1:0]     fill, fill_after, cap_m1;
  logic [CW-1:0]     tail_inc, head_inc, head_sum;
  logic [CW-1:0]     cnt_ext;
  logic              is_empty_now, is_full_now;
  logic [1:0]        status_c;
  logic [CW-1:0]     moved_c;
  logic              hw_sel_c;

  logic              hw_sel;
  logic [1:0]        status_r;
  logic [CW-1:0]     moved_r, fill_r;

  assign accept   = in_valid & in_ready;
  assign in_ready = ~out_valid | out_ready;

  assign cap_m1       = cfg.cap - CW'(1);
  assign fill         = (tail >= head) ? CW'(tail) - CW'(head)
                                       : CW'(tail) + cfg.cap - CW'(head);
  assign is_empty_now = (fill == '0);
  assign is_full_now  = (fill == cap_m1);
  assign cnt_ext      = CW'(in_count);

  assign tail_inc = (CW'(tail) + CW'(1) == cfg.cap) ? '0 : CW'(tail) + CW'(1);
  assign head_inc = (CW'(head) + CW'(1) == cfg.cap) ? '0 : CW'(head) + CW'(1);
  assign head_sum = (CW'(head) + cnt_ext >= cfg.cap) ? CW'(head) + cnt_ext - cfg.cap
                                                     : CW'(head) + cnt_ext;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    status_c   = cfq_pkg::ST_OK;
    moved_c    = '0;
    fill_after = fill;
    hw_sel_c   = 1'b0;
    mreq       = '0;
    mreq.waddr = tail;
    mreq.wdata = in_word;
    mreq.raddr = head;
    case (cfq_pkg::cmd_t'(in_cmd))
      cfq_pkg::CMD_ENQ: begin
        if (is_full_now) begin
          status_c = cfq_pkg::ST_FULL;
        end else begin
          mreq.we    = accept;
          tail_next  = tail_inc[PW-1:0];
          fill_after = fill + CW'(1);
        end
      end
      cfq_pkg::CMD_DROP, cfq_pkg::CMD_PEEK, cfq_pkg::CMD_POP: begin
        if (is_empty_now) begin
          status_c = cfq_pkg::ST_EMPTY;
        end else begin
          if (in_cmd != cfq_pkg::CMD_DROP) begin
            hw_sel_c = 1'b1;
            mreq.re  = accept;
          end
          if (in_cmd != cfq_pkg::CMD_PEEK) begin
            head_next  = head_inc[PW-1:0];
            fill_after = fill - CW'(1);
          end
        end
      end
      cfq_pkg::CMD_DROPN: begin
        if (cnt_ext > fill) begin
          moved_c    = fill;
          head_next  = '0;
          tail_next  = '0;
          fill_after = '0;
        end else begin
          moved_c    = cnt_ext;
          head_next  = head_sum[PW-1:0];
          fill_after = fill - cnt_ext;
        end
      end
      cfq_pkg::CMD_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        fill_after = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clr) begin
      head <= '0;
      tail <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hw_sel   <= hw_sel_c;
      status_r <= status_c;
      moved_r  <= moved_c;
      fill_r   <= fill_after;
    end
  end

  assign out_status    = status_r;
  assign out_head_word = hw_sel ? mem_rdata : '0;
  assign out_moved     = moved_r[cfq_pkg::CNT_W-1:0];
  assign out_fill      = fill_r[cfq_pkg::CNT_W-1:0];
  assign out_free      = cfq_pkg::CNT_W'(cap_m1 - fill_r);
  assign out_empty     = (fill_r == '0);
  assign out_full      = (fill_r == cap_m1);

endmodule

@@ design/circular_fifo_queue_top.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// ring buffer fifo with command interface and apb capacity register
// ----------------------------------------------------------------------------
// The block takes one command item per clock unless a result waits untaken,
// returning one result item for each in the cycle after acceptance; a full result
// register accepts a new command in the cycle it is taken. The words live in a single
// synchronous ram with one write port for enqueue and one read port for peek
// and pop, whose registered read data feeds the result directly. Ring size is
// set by slots_in_use at address 0 (values below 2 act as 2, above 256 as
// 256); writing it empties the queue and must only happen while idle.
module circular_fifo_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // push_word[7:0], drop_count[15:8]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // head_word[7:0], moved_count[15:8], fill_level[23:16],
                                 // free_slots[31:24], is_empty[32], is_full[33], zero[39:34]
  output logic [1:0]  m_tuser    // status[1:0]
);

  logic [cfq_pkg::CAP_W-1:0]     slots_in_use;
  logic                          cfg_wr;
  cfq_pkg::cfg_ctl_t             cfg;
  cfq_pkg::mem_req_t             mreq;
  logic [cfq_pkg::WORD_BITS-1:0] rdata;
  logic [1:0]                    status;
  logic [7:0]                    head_word, moved_count, fill_level, free_slots;
  logic                          is_empty, is_full;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(slots_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= cfq_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      slots_in_use <= pwdata[cfq_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    cfg.clr = cfg_wr;
    if (slots_in_use < cfq_pkg::CAP_MIN) begin
      cfg.cap = cfq_pkg::CAP_MIN;
    end else if (slots_in_use > cfq_pkg::CAP_MAX) begin
      cfg.cap = cfq_pkg::CAP_MAX;
    end else begin
      cfg.cap = slots_in_use;
    end
  end

  cfq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_cmd        (s_tuser),
    .in_word       (s_tdata[7:0]),
    .in_count      (s_tdata[15:8]),
    .mreq          (mreq),
    .mem_rdata     (rdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (status),
    .out_head_word (head_word),
    .out_moved     (moved_count),
    .out_fill      (fill_level),
    .out_free      (free_slots),
    .out_empty     (is_empty),
    .out_full      (is_full)
  );

  cfq_ram #(
    .DEPTH (cfq_pkg::MAX_SLOTS),
    .WIDTH (cfq_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  assign m_tuser = status;
  assign m_tdata = {6'b0, is_full, is_empty, free_slots, fill_level, moved_count, head_word};

endmodule

@@ tb/tb_circular_fifo_queue_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue_top
// self-checking bench for the command-driven ring buffer fifo
// ----------------------------------------------------------------------------
// Commands go in on the slave stream from a pending queue, with random gaps on
// both sides. A behavioral ring model tracks head, tail and stored words and
// predicts the result item of every accepted command; the monitor compares
// each result field by field in order. The ring size register is rewritten
// between phases, covering the smallest and largest rings and values that
// clamp, while the directed opening walks refusals, drop-n overflow, clear
// and the spare command codes.
// ----------------------------------------------------------------------------
module tb_circular_fifo_queue_top;

  localparam int          CLK_PERIOD  = 8;
  localparam int          CYCLE_LIMIT = 250000;
  localparam logic [2:0]  SLOTS_ADDR  = 3'd0;
  localparam logic [2:0]  CMD_SPARE6  = 3'd6;
  localparam logic [2:0]  CMD_SPARE7  = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] word;
    logic [7:0] count;
  } command_t;

  typedef struct packed {
    cfq_pkg::status_t status;
    logic [7:0]       head_word;
    logic [7:0]       moved;
    logic [7:0]       fill;
    logic [7:0]       free;
    logic             empty;
    logic             full;
  } outcome_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // push_word[7:0], drop_count[15:8]
  logic [2:0]  s_tuser  = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // head_word, moved_count, fill_level, free_slots,
                                // is_empty[32], is_full[33]
  logic [1:0]  m_tuser;         // status[1:0]

  circular_fifo_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ring model
  logic [7:0] ring_words [cfq_pkg::MAX_SLOTS];
  int         ring_head  = 0;
  int         ring_tail  = 0;
  int         ring_size  = cfq_pkg::MAX_SLOTS;

  command_t   cmd_pending [$];
  outcome_t   outcome_q   [$];
  command_t   next_cmd;
  outcome_t   want;
  bit         cmd_taken      = 1'b0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  function automatic int clamp_slots(logic [31:0] value);
    int v;
    v = int'(value[8:0]);
    if (v < 2) return 2;
    if (v > cfq_pkg::MAX_SLOTS) return cfq_pkg::MAX_SLOTS;
    return v;
  endfunction

  function automatic outcome_t apply_command(logic [2:0] cmd, logic [7:0] word,
                                             logic [7:0] count);
    outcome_t r;
    int       fill;
    r        = '0;
    r.status = cfq_pkg::ST_OK;
    fill     = (ring_tail - ring_head + ring_size) % ring_size;
    case (cmd)
      cfq_pkg::CMD_ENQ: begin
        if (fill >= ring_size - 1) begin
          r.status = cfq_pkg::ST_FULL;
        end else begin
          ring_words[ring_tail] = word;
          ring_tail = (ring_tail + 1) % ring_size;
        end
      end
      cfq_pkg::CMD_DROP, cfq_pkg::CMD_PEEK, cfq_pkg::CMD_POP: begin
        if (fill == 0) begin
          r.status = cfq_pkg::ST_EMPTY;
        end else begin
          if (cmd != cfq_pkg::CMD_DROP) r.head_word = ring_words[ring_head];
          if (cmd != cfq_pkg::CMD_PEEK) ring_head = (ring_head + 1) % ring_size;
        end
      end
      cfq_pkg::CMD_DROPN: begin
        if (int'(count) > fill) begin
          r.moved   = 8'(fill);
          ring_head = 0;
          ring_tail = 0;
        end else begin
          r.moved   = count;
          ring_head = (ring_head + int'(count)) % ring_size;
        end
      end
      cfq_pkg::CMD_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
      end
      default: ;
    endcase
    fill    = (ring_tail - ring_head + ring_size) % ring_size;
    r.fill  = 8'(fill);
    r.free  = 8'(ring_size - 1 - fill);
    r.empty = (fill == 0);
    r.full  = (fill == ring_size - 1);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // slave side driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || cmd_taken) begin
      if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = cmd_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_cmd.cmd;
        s_tdata  <= {next_cmd.count, next_cmd.word};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  // master side stall
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(apply_command(s_tuser, s_tdata[7:0], s_tdata[15:8]));
        cmd_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 8'(m_tuser), 8'(want.status));
          check_field("head_word", m_tdata[7:0], want.head_word);
          check_field("moved_count", m_tdata[15:8], want.moved);
          check_field("fill_level", m_tdata[23:16], want.fill);
          check_field("free_slots", m_tdata[31:24], want.free);
          check_field("is_empty", 8'(m_tdata[32]), 8'(want.empty));
          check_field("is_full", 8'(m_tdata[33]), 8'(want.full));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_fifo_queue_top test failed");
      $finish;
    end
  end

  task automatic add_cmd(logic [2:0] cmd, logic [7:0] word, logic [7:0] count);
    command_t c;
    c.cmd   = cmd;
    c.word  = word;
    c.count = count;
    cmd_pending.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmd_pending.size() != 0 || s_tvalid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_ring_size(logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOTS_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ring_size = clamp_slots(value);
    ring_head = 0;
    ring_tail = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_random(int count, int enq_pct);
    int         pick;
    logic [2:0] cmd;
    logic [7:0] n;
    for (int i = 0; i < count; i++) begin
      n = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
      if ($urandom_range(99) < enq_pct) begin
        cmd = cfq_pkg::CMD_ENQ;
      end else begin
        pick = $urandom_range(99);
        if (pick < 25)      cmd = cfq_pkg::CMD_DROP;
        else if (pick < 50) cmd = cfq_pkg::CMD_PEEK;
        else if (pick < 75) cmd = cfq_pkg::CMD_POP;
        else if (pick < 90) cmd = cfq_pkg::CMD_DROPN;
        else if (pick < 96) cmd = cfq_pkg::CMD_CLEAR;
        else                cmd = $urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6;
      end
      add_cmd(cmd, 8'($urandom_range(255)), n);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int count, int enq_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random(count, enq_pct);
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset ring size, empty queue refusals
    add_cmd(cfq_pkg::CMD_PEEK,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_POP,   8'hff, 8'hff);
    add_cmd(cfq_pkg::CMD_DROP,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_DROPN, 8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_DROPN, 8'h00, 8'h05);
    add_cmd(cfq_pkg::CMD_ENQ,   8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_ENQ,   8'hff, 8'hff);
    add_cmd(cfq_pkg::CMD_ENQ,   8'ha5, 8'h00);
    add_cmd(cfq_pkg::CMD_ENQ,   8'h5a, 8'h00);
    add_cmd(cfq_pkg::CMD_PEEK,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_POP,   8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_DROP,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_PEEK,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_DROPN, 8'h00, 8'hff);
    add_cmd(cfq_pkg::CMD_ENQ,   8'h81, 8'h00);
    add_cmd(cfq_pkg::CMD_CLEAR, 8'hff, 8'hff);
    add_cmd(CMD_SPARE6,         8'h12, 8'h34);
    add_cmd(CMD_SPARE7,         8'hff, 8'hff);
    wait_idle();

    // smallest ring: one word deep
    set_ring_size(32'd2);
    add_cmd(cfq_pkg::CMD_ENQ,   8'h3c, 8'h00);
    add_cmd(cfq_pkg::CMD_ENQ,   8'hc3, 8'h00);
    add_cmd(cfq_pkg::CMD_PEEK,  8'h00, 8'h00);
    add_cmd(cfq_pkg::CMD_DROPN, 8'h00, 8'h01);
    add_cmd(cfq_pkg::CMD_ENQ,   8'h77, 8'h00);
    add_cmd(cfq_pkg::CMD_POP,   8'h00, 8'h00);
    wait_idle();

    run_phase(0, 0, 120, 55);
    set_ring_size(32'd0);
    run_phase(81, 0, 80, 60);
    set_ring_size(32'd3);
    run_phase(0, 81, 120, 55);
    set_ring_size(32'd17);
    run_phase(36, 36, 200, 60);
    set_ring_size(32'd256);
    run_phase(0, 0, 330, 92);
    run_phase(81, 0, 150, 15);
    set_ring_size(32'd511);
    run_phase(0, 81, 150, 50);
    set_ring_size(32'd1);
    run_phase(36, 36, 100, 50);
    set_ring_size(32'd255);
    run_phase(0, 0, 200, 70);

    repeat (5) @(posedge clk);
    if (mismatch_count == 0)
      $display("circular_fifo_queue_top test passed");
    else
      $display("circular_fifo_queue_top test failed");
    $finish;
  end

endmodule
